// ===== design/iud_pkg.sv =====
`timescale 1ns / 1ps

package iud_pkg;

   // Sequencer states of the divider.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_WRITE  = 2'd2
   } iud_state_type;

   // Commands from the sequencer to the shared shift-subtract datapath.
   typedef struct packed {
      logic load;
      logic step;
   } iud_ctl_type;

endpackage

// ===== design/iud_if.sv =====
`timescale 1ns / 1ps

interface iud_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] dividend;
   logic [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface iud_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] quotient;
   logic                  divide_by_zero;

   modport source (output valid, output quotient, output divide_by_zero, input ready);
   modport sink   (input valid, input quotient, input divide_by_zero, output ready);
endinterface

// ===== design/iud_datapath.sv =====
`timescale 1ns / 1ps

// Restoring divider datapath: one quotient bit per step through a single
// compare-and-subtract unit.
module iud_datapath
   import iud_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  iud_ctl_type           ctl,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic [DATA_WIDTH-1:0] quotient
);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH+1:0] diff;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~diff[DATA_WIDTH+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (ctl.load) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
      end else if (ctl.step) begin
         // The partial remainder stays below the divisor, so either branch fits.
         rem_in = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;

endmodule

// ===== design/iterative_unsigned_divider.sv =====
`timescale 1ns / 1ps

// Unsigned integer divider. Each request beat carries a dividend and a
// divisor and produces one response beat with quotient = floor(dividend /
// divisor). The quotient is formed one bit per clock by a single restoring
// compare-and-subtract unit. The operands load at the edge that accepts the
// request beat, then the iteration runs once per quotient bit and the write
// state loads the response into the output register. The request side is
// not ready while a division is in progress; it is ready again in the cycle
// after the write. A zero divisor skips the iteration, sets divide_by_zero
// and returns the last quotient computed (zero after reset); its response
// also passes through the write state. The response sits in an output
// register, so a new request is taken while a finished response still waits
// for its consumer; the write cycle repeats, and the next result is held
// back, only while that register is still full.
module iterative_unsigned_divider
   import iud_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   iud_req_if.sink   req_bus,
   iud_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(DATA_WIDTH);

   iud_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  zero_ff, zero_in;
   logic [DATA_WIDTH-1:0] last_quotient_ff, last_quotient_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_quotient_ff, rsp_quotient_in;
   logic                  rsp_zero_ff, rsp_zero_in;

   iud_ctl_type           ctl;
   logic [DATA_WIDTH-1:0] dp_quotient;
   logic                  req_fire;
   logic                  slot_free;

   iud_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .ctl      (ctl),
      .dividend (req_bus.dividend),
      .divisor  (req_bus.divisor),
      .quotient (dp_quotient)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   // The output register can take a new result when empty or being drained.
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         last_quotient_ff <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         last_quotient_ff <= last_quotient_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff        <= count_in;
      zero_ff         <= zero_in;
      rsp_quotient_ff <= rsp_quotient_in;
      rsp_zero_ff     <= rsp_zero_in;
   end

   // Sequencer: next state, datapath commands and response register loads.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      zero_in          = zero_ff;
      last_quotient_in = last_quotient_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_quotient_in  = rsp_quotient_ff;
      rsp_zero_in      = rsp_zero_ff;
      ctl              = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               zero_in  = (req_bus.divisor == '0);
               count_in = CNT_W'(DATA_WIDTH - 1);
               ctl.load = 1'b1;
               // A zero divisor needs no iteration; its result goes straight to the write state.
               state_in = (req_bus.divisor == '0) ? ST_WRITE : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            ctl.step = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_zero_in  = zero_ff;
               if (zero_ff) begin
                  rsp_quotient_in = last_quotient_ff;
               end else begin
                  rsp_quotient_in  = dp_quotient;
                  last_quotient_in = dp_quotient;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.quotient       = rsp_quotient_ff;
   assign rsp_bus.divide_by_zero = rsp_zero_ff;

`ifndef SYNTHESIS
   // An accepted request always starts work, so the block stops taking beats.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request beat accepted but sequencer stayed idle");

   // The iteration runs all DATA_WIDTH steps before the result is written.
   a_divide_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && count_ff != '0) |=> state_ff == ST_DIVIDE)
      else $error("division left the iteration early");

   // A pending response always matches the stored quotient, which a zero
   // divisor must leave untouched.
   a_last_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_quotient_ff == last_quotient_ff)
      else $error("pending quotient differs from stored last quotient");
`endif

endmodule

// ===== tb/sv/iterative_unsigned_divider_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the iterative unsigned divider. Each request beat is scored
// by a small predictor that keeps its own copy of the quotient register, and
// each response beat is compared with the oldest prediction still pending.
module iterative_unsigned_divider_tb;

   localparam int WIDTH = 32;

   // This leaves room for the longest run of random response stalls on top of
   // a full division.
   localparam int STALL_LIMIT = 4000;

   // Cycles allowed after the last response for any stray beat to show up.
   localparam int SETTLE_CYCLES = 3 * (WIDTH + 2);

   localparam int RANDOM_ITEMS = 1630;

   typedef logic [WIDTH-1:0] word_type;

   // One predicted response beat.
   typedef struct {
      word_type quotient;
      logic     divide_by_zero;
   } quotient_beat_type;

   // Predicts the quotient of every accepted request and checks response beats
   // in order against those predictions.
   class quotient_scoreboard;
      word_type          last_quotient;
      quotient_beat_type pending_quotients[$];
      int                mismatch_count;

      function new();
         last_quotient = '0;
         mismatch_count = 0;
      endfunction

      function int outstanding();
         return pending_quotients.size();
      endfunction

      // A zero divisor flags the error and repeats the held quotient. Any other
      // divisor, one included, replaces the held quotient with the floor quotient.
      function void note_request(word_type dividend, word_type divisor);
         quotient_beat_type beat;
         if (divisor == '0) begin
            beat.divide_by_zero = 1'b1;
         end else begin
            last_quotient = dividend / divisor;
            beat.divide_by_zero = 1'b0;
         end
         beat.quotient = last_quotient;
         pending_quotients.push_back(beat);
      endfunction

      function void check_response(word_type quotient, logic divide_by_zero);
         quotient_beat_type beat;
         if (pending_quotients.size() == 0) begin
            $error("unexpected response beat: quotient %0d, divide_by_zero %0b",
                   quotient, divide_by_zero);
            mismatch_count++;
            return;
         end
         beat = pending_quotients.pop_front();
         if (quotient !== beat.quotient) begin
            $error("quotient: expected %0d, actual %0d", beat.quotient, quotient);
            mismatch_count++;
         end
         if (divide_by_zero !== beat.divide_by_zero) begin
            $error("divide_by_zero: expected %0b, actual %0b",
                   beat.divide_by_zero, divide_by_zero);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   // While set, neither the request side nor the response side idles.
   logic steady_flow = 1'b0;

   int stall_cycles = 0;

   quotient_scoreboard scoreboard = new();

   iud_req_if #(.DATA_WIDTH(WIDTH)) req_bus ();
   iud_rsp_if #(.DATA_WIDTH(WIDTH)) rsp_bus ();

   iterative_unsigned_divider #(
      .DATA_WIDTH(WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // Every input is known from time zero.
   initial begin
      req_bus.valid    = 1'b0;
      req_bus.dividend = '0;
      req_bus.divisor  = '0;
      rsp_bus.ready    = 1'b0;
   end

   // The response side stalls at random about 38 percent of the time, except during
   // the steady stretch. Inputs change on the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 38);
      end
   end

   // Both channels are sampled on the rising edge. A request beat is scored
   // at the edge that accepts it, and a response beat is checked at its own.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            scoreboard.note_request(req_bus.dividend, req_bus.divisor);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            scoreboard.check_response(rsp_bus.quotient, rsp_bus.divide_by_zero);
         end
      end
   end

   // The watchdog ends a run in which no beat moves on either channel for too
   // long, which is the only way a hung divider shows up.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Offers one request beat and returns at the falling edge after it was
   // accepted. It is entered at a falling edge. Random idle cycles come first,
   // so valid stays high between back-to-back beats when no idle is drawn.
   task automatic send_division(input word_type dividend, input word_type divisor);
      while (!steady_flow && ($urandom_range(99) < 38)) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.dividend <= dividend;
      req_bus.divisor  <= divisor;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Holds the request side quiet until every predicted response has arrived.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (scoreboard.outstanding() != 0) begin
         @(negedge clock);
      end
   endtask

   // Draws one random request. Most draws are full-width words or a divisor
   // shifted down by a random amount, so the quotient length varies over the
   // whole word; the rest aim at the special cases.
   task automatic send_random_division();
      word_type dividend;
      word_type divisor;
      int       pick;
      pick = $urandom_range(99);
      dividend = $urandom;
      divisor = $urandom;
      if (pick < 40) begin
         // Both operands are already full-width random words.
      end else if (pick < 65) begin
         divisor = divisor >> $urandom_range(WIDTH - 1);
      end else if (pick < 73) begin
         divisor = '0;
      end else if (pick < 79) begin
         divisor = 1;
      end else if (pick < 89) begin
         // The dividend sits below the divisor, so the quotient is zero.
         if (divisor != '0) begin
            dividend = dividend % divisor;
         end
      end else begin
         dividend = $urandom_range(15);
         divisor = $urandom_range(15);
      end
      send_division(dividend, divisor);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A zero divisor straight out of reset must return the cleared quotient.
      send_division(32'd12345, 32'd0);
      send_division('1, '1);
      send_division('1, 32'd1);
      send_division('1, 32'd0);
      send_division(32'd0, '1);
      send_division(32'd0, 32'd0);
      send_division('1, 32'd2);
      send_division(32'd0, 32'd1);
      send_division(32'd1, 32'd0);
      send_division(32'd7, 32'd3);
      send_division(32'd6, 32'd3);
      send_division(32'd2, 32'd3);
      send_division('1, 32'h8000_0000);
      send_division(32'h7FFF_FFFF, 32'h8000_0000);
      send_division('1, 32'h0001_0000);
      send_division(32'h8000_0000, 32'h0000_0002);
      send_division(32'hAAAA_AAAA, 32'h5555_5555);
      send_division(32'h5555_5555, 32'hAAAA_AAAA);
      send_division(32'd1, 32'd1);
      send_division(32'd100, 32'd0);
      send_division(32'd99, 32'd100);
      send_division(32'd100, 32'd100);

      drain_responses();

      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         // Both sides run without idling through one long stretch.
         steady_flow = (item >= 600) && (item < 900);
         if (item == 1200) begin
            drain_responses();
         end
         send_random_division();
      end
      steady_flow = 1'b0;

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (scoreboard.mismatch_count == 0 && scoreboard.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
